@@ rtl/efrc_pkg.sv @@
// ----------------------------------------------------------------------------
// efrc_pkg: shared types and constants of the exhaust fan relay controller
// Holds the tick and result word layouts, the register map and reset values.
// ----------------------------------------------------------------------------
package efrc_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned HUMID_W     = 10;
  localparam int unsigned MINUTE_W    = 11;
  localparam int unsigned TICKS_W     = 16;

  localparam logic [HUMID_W-1:0]  HUMID_ON_RESET    = HUMID_W'(600);
  localparam logic [HUMID_W-1:0]  HUMID_OFF_RESET   = HUMID_W'(550);
  localparam logic [TICKS_W-1:0]  PRESENCE_RESET    = TICKS_W'(300);
  localparam logic [TICKS_W-1:0]  HUMID_RUN_RESET   = TICKS_W'(60);
  localparam logic [TICKS_W-1:0]  HUMID_MIN_RESET   = TICKS_W'(30);
  localparam logic [TICKS_W-1:0]  LOCKOUT_RESET     = TICKS_W'(120);
  localparam logic [MINUTE_W-1:0] IGNORE_START_RESET = MINUTE_W'(22 * 60);
  localparam logic [MINUTE_W-1:0] IGNORE_END_RESET   = MINUTE_W'(6 * 60);
  localparam logic [TICKS_W-1:0]  IDLE_LOCK_TICKS   = TICKS_W'(5);
  localparam logic [TICKS_W-1:0]  RESET_LOCK_TICKS  = TICKS_W'(15);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HUMID_ON_LEVEL      = 3'd0,
    REG_HUMID_OFF_LEVEL     = 3'd1,
    REG_PRESENCE_RUN_TICKS  = 3'd2,
    REG_HUMID_RUN_TICKS     = 3'd3,
    REG_HUMID_MIN_TICKS     = 3'd4,
    REG_LOCKOUT_TICKS       = 3'd5,
    REG_IGNORE_START_MINUTE = 3'd6,
    REG_IGNORE_END_MINUTE   = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [HUMID_W-1:0]  humid_on_level;
    logic [HUMID_W-1:0]  humid_off_level;
    logic [TICKS_W-1:0]  presence_run_ticks;
    logic [TICKS_W-1:0]  humid_run_ticks;
    logic [TICKS_W-1:0]  humid_min_ticks;
    logic [TICKS_W-1:0]  lockout_ticks;
    logic [MINUTE_W-1:0] ignore_start_minute;
    logic [MINUTE_W-1:0] ignore_end_minute;
  } cfg_t;

  typedef struct packed {
    logic                sample_valid;
    logic [HUMID_W-1:0]  humidity;
    logic                motion_seen;
    logic                clock_valid;
    logic [MINUTE_W-1:0] minute_of_day;
    logic                switch_flip;
  } tick_t;

  typedef struct packed {
    logic               relay_drive;
    logic               humid_flag;
    logic [TICKS_W-1:0] run_left;
    logic [TICKS_W-1:0] lock_left;
  } result_t;

  typedef struct packed {
    logic [TICKS_W-1:0] run_count;
    logic [TICKS_W-1:0] lock_count;
    logic               humid_high;
    logic               motion_pending;
    logic               relay_state;
  } state_t;

endpackage

@@ rtl/efrc_if.sv @@
// ----------------------------------------------------------------------------
// efrc_if: valid/ready channels of the exhaust fan relay controller
// One channel carries tick words in, the other carries result words out.
// ----------------------------------------------------------------------------
interface efrc_tick_if;
  logic                             valid;
  logic                             ready;
  logic                             sample_valid;
  logic [efrc_pkg::HUMID_W-1:0]     humidity;
  logic                             motion_seen;
  logic                             clock_valid;
  logic [efrc_pkg::MINUTE_W-1:0]    minute_of_day;
  logic                             switch_flip;

  modport source (output valid, sample_valid, humidity, motion_seen, clock_valid,
                  minute_of_day, switch_flip, input ready);
  modport sink (input valid, sample_valid, humidity, motion_seen, clock_valid,
                minute_of_day, switch_flip, output ready);
endinterface

interface efrc_result_if;
  logic                          valid;
  logic                          ready;
  logic                          relay_drive;
  logic                          humid_flag;
  logic [efrc_pkg::TICKS_W-1:0]  run_left;
  logic [efrc_pkg::TICKS_W-1:0]  lock_left;

  modport source (output valid, relay_drive, humid_flag, run_left, lock_left,
                  input ready);
  modport sink (input valid, relay_drive, humid_flag, run_left, lock_left,
                output ready);
endinterface

@@ rtl/exhaust_fan_relay_controller_top.sv @@
// ----------------------------------------------------------------------------
// exhaust_fan_relay_controller_top: exhaust fan relay controller
// The input register takes a tick word; the result register loads its result
// word when the result channel is empty or being taken. Throughput: one tick
// word per cycle unless results stall, set by the input and result registers.
// Reset: synchronous; registers return to their defaults, run count to 0,
// lock count to 15, relay off, and both channels empty.
// ----------------------------------------------------------------------------
module exhaust_fan_relay_controller_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [efrc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [efrc_pkg::CFG_DATA_W-1:0]   cfg_data,
  efrc_tick_if.sink                         tick,
  efrc_result_if.source                     result
);

  efrc_pkg::cfg_t    cfg;
  efrc_pkg::state_t  state;
  efrc_pkg::state_t  state_next;
  efrc_pkg::tick_t   tick_reg;
  efrc_pkg::result_t step_result;
  efrc_pkg::result_t result_reg;
  logic              tick_valid;
  logic              result_valid;
  logic              advance;

  assign advance    = tick_valid && (!result_valid || result.ready);
  assign tick.ready = !tick_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.humid_on_level      <= efrc_pkg::HUMID_ON_RESET;
      cfg.humid_off_level     <= efrc_pkg::HUMID_OFF_RESET;
      cfg.presence_run_ticks  <= efrc_pkg::PRESENCE_RESET;
      cfg.humid_run_ticks     <= efrc_pkg::HUMID_RUN_RESET;
      cfg.humid_min_ticks     <= efrc_pkg::HUMID_MIN_RESET;
      cfg.lockout_ticks       <= efrc_pkg::LOCKOUT_RESET;
      cfg.ignore_start_minute <= efrc_pkg::IGNORE_START_RESET;
      cfg.ignore_end_minute   <= efrc_pkg::IGNORE_END_RESET;
    end else if (cfg_write) begin
      unique case (efrc_pkg::cfg_index_t'(cfg_index))
        efrc_pkg::REG_HUMID_ON_LEVEL: begin
          cfg.humid_on_level <= cfg_data[efrc_pkg::HUMID_W-1:0];
        end
        efrc_pkg::REG_HUMID_OFF_LEVEL: begin
          cfg.humid_off_level <= cfg_data[efrc_pkg::HUMID_W-1:0];
        end
        efrc_pkg::REG_PRESENCE_RUN_TICKS: begin
          cfg.presence_run_ticks <= cfg_data;
        end
        efrc_pkg::REG_HUMID_RUN_TICKS: begin
          cfg.humid_run_ticks <= cfg_data;
        end
        efrc_pkg::REG_HUMID_MIN_TICKS: begin
          cfg.humid_min_ticks <= cfg_data;
        end
        efrc_pkg::REG_LOCKOUT_TICKS: begin
          cfg.lockout_ticks <= cfg_data;
        end
        efrc_pkg::REG_IGNORE_START_MINUTE: begin
          cfg.ignore_start_minute <= cfg_data[efrc_pkg::MINUTE_W-1:0];
        end
        efrc_pkg::REG_IGNORE_END_MINUTE: begin
          cfg.ignore_end_minute <= cfg_data[efrc_pkg::MINUTE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (tick.ready) begin
      tick_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      tick_reg.sample_valid  <= tick.sample_valid;
      tick_reg.humidity      <= tick.humidity;
      tick_reg.motion_seen   <= tick.motion_seen;
      tick_reg.clock_valid   <= tick.clock_valid;
      tick_reg.minute_of_day <= tick.minute_of_day;
      tick_reg.switch_flip   <= tick.switch_flip;
    end
  end

  efrc_step u_step (
    .cfg        (cfg),
    .state      (state),
    .tick       (tick_reg),
    .state_next (state_next),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.run_count      <= '0;
      state.lock_count     <= efrc_pkg::RESET_LOCK_TICKS;
      state.humid_high     <= 1'b0;
      state.motion_pending <= 1'b0;
      state.relay_state    <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_reg <= step_result;
    end
  end

  assign result.valid       = result_valid;
  assign result.relay_drive = result_reg.relay_drive;
  assign result.humid_flag  = result_reg.humid_flag;
  assign result.run_left    = result_reg.run_left;
  assign result.lock_left   = result_reg.lock_left;

endmodule

@@ rtl/efrc_step.sv @@
// ----------------------------------------------------------------------------
// efrc_step: next-state logic for one tick
// Applies humidity, motion, switch and relay rules in that order.
// ----------------------------------------------------------------------------
module efrc_step (
  input  efrc_pkg::cfg_t    cfg,
  input  efrc_pkg::state_t  state,
  input  efrc_pkg::tick_t   tick,
  output efrc_pkg::state_t  state_next,
  output efrc_pkg::result_t result
);

  always_comb begin
    logic [efrc_pkg::TICKS_W-1:0] run;
    logic [efrc_pkg::TICKS_W-1:0] lock;
    logic                         high;
    logic                         pending;
    logic                         relay;
    logic                         in_window;

    run     = state.run_count;
    lock    = state.lock_count;
    high    = state.humid_high;
    pending = state.motion_pending | tick.motion_seen;
    relay   = state.relay_state;

    if (cfg.ignore_start_minute < cfg.ignore_end_minute) begin
      in_window = (tick.minute_of_day >= cfg.ignore_start_minute) &&
                  (tick.minute_of_day < cfg.ignore_end_minute);
    end else begin
      in_window = (tick.minute_of_day >= cfg.ignore_start_minute) ||
                  (tick.minute_of_day < cfg.ignore_end_minute);
    end

    if (tick.sample_valid) begin
      if (tick.humidity >= cfg.humid_on_level) begin
        high = 1'b1;
      end else if (tick.humidity <= cfg.humid_off_level) begin
        high = 1'b0;
      end
      if (high && (lock == '0) && (run < cfg.humid_min_ticks)) begin
        run = cfg.humid_run_ticks;
      end
    end

    if (pending && tick.clock_valid) begin
      pending = 1'b0;
      if (!in_window && (lock == '0)) begin
        run = cfg.presence_run_ticks;
      end
    end

    if (tick.switch_flip) begin
      if (run != '0) begin
        run  = '0;
        lock = cfg.lockout_ticks;
      end else begin
        run  = cfg.presence_run_ticks;
        lock = '0;
      end
    end

    if (lock != '0) begin
      lock  = lock - 1'b1;
      relay = 1'b0;
    end else if (run != '0) begin
      run   = run - 1'b1;
      relay = 1'b1;
    end else begin
      if (relay) begin
        lock = efrc_pkg::IDLE_LOCK_TICKS;
      end
      relay = 1'b0;
    end

    state_next.run_count      = run;
    state_next.lock_count     = lock;
    state_next.humid_high     = high;
    state_next.motion_pending = pending;
    state_next.relay_state    = relay;

    result.relay_drive = relay;
    result.humid_flag  = high;
    result.run_left    = run;
    result.lock_left   = lock;
  end

endmodule

@@ rtl/efrc_checker.sv @@
// ----------------------------------------------------------------------------
// efrc_checker: port-level checks of the exhaust fan relay controller
// Checks the result channel: relay/countdown consistency, reset, stall hold.
// ----------------------------------------------------------------------------
module efrc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          relay_drive,
  input logic                          humid_flag,
  input logic [efrc_pkg::TICKS_W-1:0]  run_left,
  input logic [efrc_pkg::TICKS_W-1:0]  lock_left
);

  // A running fan never shows a lockout in progress.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && relay_drive) |-> (lock_left == '0))
    else $error("relay on while lockout remains");

  // A stopped fan has no run time left, since lockouts always clear the run.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !relay_drive) |-> (run_left == '0))
    else $error("relay off with run time remaining");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(relay_drive) && $stable(humid_flag) &&
       $stable(run_left) && $stable(lock_left)))
    else $error("stalled result word changed");

endmodule

bind exhaust_fan_relay_controller_top efrc_checker u_efrc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .relay_drive (result.relay_drive),
  .humid_flag  (result.humid_flag),
  .run_left    (result.run_left),
  .lock_left   (result.lock_left)
);

@@ sim/tb_exhaust_fan_relay_controller_top.sv @@
// ----------------------------------------------------------------------------
// tb_exhaust_fan_relay_controller_top: self-checking bench of the fan relay controller
// A queue-fed driver sends tick words and a monitor checks every result word
// against an in-bench model of the humidity, motion, switch and relay logic.
// Register settings change between phases, and the idle mix rotates per phase.
// ----------------------------------------------------------------------------
module tb_exhaust_fan_relay_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_TICKS = 1950;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned HUM_BITS     = efrc_pkg::HUMID_W;
  localparam int unsigned MIN_BITS     = efrc_pkg::MINUTE_W;
  localparam int unsigned CNT_BITS     = efrc_pkg::TICKS_W;
  localparam int unsigned DATA_BITS    = efrc_pkg::CFG_DATA_W;

  logic                                clk;
  logic                                rst;
  logic                                cfg_write;
  logic [efrc_pkg::CFG_INDEX_W-1:0]    cfg_index;
  logic [efrc_pkg::CFG_DATA_W-1:0]     cfg_data;

  efrc_tick_if   tick_ch ();
  efrc_result_if result_ch ();

  exhaust_fan_relay_controller_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .result    (result_ch)
  );

  efrc_pkg::tick_t   pending_ticks[$];
  efrc_pkg::result_t expected_outputs[$];
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  int unsigned       mismatch_count;
  int unsigned       cycle_count;
  bit                tick_taken;

  efrc_pkg::cfg_t                fan_cfg;
  logic [efrc_pkg::TICKS_W-1:0]  run_cnt;
  logic [efrc_pkg::TICKS_W-1:0]  lock_cnt;
  logic                          humid_hi;
  logic                          motion_pend;
  logic                          fan_running;

  task automatic predict_fan_tick(input efrc_pkg::tick_t t, output efrc_pkg::result_t r);
    logic ignored;
    if (t.sample_valid) begin
      if (t.humidity >= fan_cfg.humid_on_level) begin
        humid_hi = 1'b1;
      end else if (t.humidity <= fan_cfg.humid_off_level) begin
        humid_hi = 1'b0;
      end
      if (humid_hi && lock_cnt == '0 && run_cnt < fan_cfg.humid_min_ticks) begin
        run_cnt = fan_cfg.humid_run_ticks;
      end
    end
    if (t.motion_seen) begin
      motion_pend = 1'b1;
    end
    if (motion_pend && t.clock_valid) begin
      motion_pend = 1'b0;
      if (fan_cfg.ignore_start_minute < fan_cfg.ignore_end_minute) begin
        ignored = t.minute_of_day >= fan_cfg.ignore_start_minute &&
                  t.minute_of_day < fan_cfg.ignore_end_minute;
      end else begin
        ignored = t.minute_of_day >= fan_cfg.ignore_start_minute ||
                  t.minute_of_day < fan_cfg.ignore_end_minute;
      end
      if (!ignored && lock_cnt == '0) begin
        run_cnt = fan_cfg.presence_run_ticks;
      end
    end
    if (t.switch_flip) begin
      if (run_cnt != '0) begin
        run_cnt  = '0;
        lock_cnt = fan_cfg.lockout_ticks;
      end else begin
        run_cnt  = fan_cfg.presence_run_ticks;
        lock_cnt = '0;
      end
    end
    if (lock_cnt != '0) begin
      lock_cnt    = lock_cnt - 1'b1;
      fan_running = 1'b0;
    end else if (run_cnt != '0) begin
      run_cnt     = run_cnt - 1'b1;
      fan_running = 1'b1;
    end else begin
      if (fan_running) begin
        lock_cnt = efrc_pkg::IDLE_LOCK_TICKS;
      end
      fan_running = 1'b0;
    end
    r.relay_drive = fan_running;
    r.humid_flag  = humid_hi;
    r.run_left    = run_cnt;
    r.lock_left   = lock_cnt;
  endtask

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    mismatch_count++;
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
  endtask

  function automatic efrc_pkg::tick_t make_tick(input int unsigned sv, input int unsigned hum,
                                                input int unsigned mot, input int unsigned cv,
                                                input int unsigned minute,
                                                input int unsigned sw);
    efrc_pkg::tick_t t;
    t.sample_valid  = 1'(sv);
    t.humidity      = HUM_BITS'(hum);
    t.motion_seen   = 1'(mot);
    t.clock_valid   = 1'(cv);
    t.minute_of_day = MIN_BITS'(minute);
    t.switch_flip   = 1'(sw);
    return t;
  endfunction

  function automatic efrc_pkg::tick_t random_tick();
    efrc_pkg::tick_t t;
    t.sample_valid = ($urandom_range(99) < 50);
    case ($urandom_range(3))
      0: t.humidity = HUM_BITS'($urandom_range(1000));
      1: t.humidity = HUM_BITS'(fan_cfg.humid_on_level + $urandom_range(4) - 2);
      2: t.humidity = HUM_BITS'(fan_cfg.humid_off_level + $urandom_range(4) - 2);
      default: t.humidity = HUM_BITS'($urandom);
    endcase
    t.motion_seen = ($urandom_range(99) < 12);
    t.clock_valid = ($urandom_range(99) < 80);
    case ($urandom_range(9))
      0: t.minute_of_day = MIN_BITS'($urandom);
      1: t.minute_of_day = MIN_BITS'(fan_cfg.ignore_start_minute + $urandom_range(2) - 1);
      2: t.minute_of_day = MIN_BITS'(fan_cfg.ignore_end_minute + $urandom_range(2) - 1);
      default: t.minute_of_day = MIN_BITS'($urandom_range(1439));
    endcase
    t.switch_flip = ($urandom_range(99) < 4);
    return t;
  endfunction

  function automatic efrc_pkg::cfg_t random_settings(input int unsigned kind);
    efrc_pkg::cfg_t c;
    c.humid_on_level      = HUM_BITS'($urandom_range(1000));
    c.humid_off_level     = HUM_BITS'($urandom_range(1000));
    c.presence_run_ticks  = CNT_BITS'($urandom_range(40));
    c.humid_run_ticks     = CNT_BITS'($urandom_range(40));
    c.humid_min_ticks     = CNT_BITS'($urandom_range(40));
    c.lockout_ticks       = CNT_BITS'($urandom_range(25));
    c.ignore_start_minute = MIN_BITS'($urandom_range(1439));
    c.ignore_end_minute   = MIN_BITS'($urandom_range(1439));
    case (kind)
      1: begin
        c.humid_on_level      = HUM_BITS'(1000);
        c.humid_off_level     = HUM_BITS'(1000);
        c.presence_run_ticks  = '1;
        c.humid_run_ticks     = '1;
        c.humid_min_ticks     = '1;
        c.lockout_ticks       = '1;
        c.ignore_start_minute = MIN_BITS'(1439);
        c.ignore_end_minute   = '0;
      end
      2: begin
        c = '0;
      end
      3: begin
        c.humid_off_level     = HUM_BITS'(c.humid_on_level / 2 + $urandom_range(500));
        c.ignore_end_minute   = c.ignore_start_minute;
      end
      default: begin
      end
    endcase
    return c;
  endfunction

  task automatic write_reg(input efrc_pkg::cfg_index_t idx,
                           input logic [efrc_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
  endtask

  task automatic apply_settings(input efrc_pkg::cfg_t c);
    write_reg(efrc_pkg::REG_HUMID_ON_LEVEL, DATA_BITS'(c.humid_on_level));
    write_reg(efrc_pkg::REG_HUMID_OFF_LEVEL, DATA_BITS'(c.humid_off_level));
    write_reg(efrc_pkg::REG_PRESENCE_RUN_TICKS, c.presence_run_ticks);
    write_reg(efrc_pkg::REG_HUMID_RUN_TICKS, c.humid_run_ticks);
    write_reg(efrc_pkg::REG_HUMID_MIN_TICKS, c.humid_min_ticks);
    write_reg(efrc_pkg::REG_LOCKOUT_TICKS, c.lockout_ticks);
    write_reg(efrc_pkg::REG_IGNORE_START_MINUTE, DATA_BITS'(c.ignore_start_minute));
    write_reg(efrc_pkg::REG_IGNORE_END_MINUTE, DATA_BITS'(c.ignore_end_minute));
    @(negedge clk);
    cfg_write <= 1'b0;
    fan_cfg = c;
  endtask

  task automatic wait_for_drain();
    while (pending_ticks.size() != 0 || tick_ch.valid || expected_outputs.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    efrc_pkg::tick_t w;
    if (rst) begin
      tick_ch.valid   <= 1'b0;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!tick_ch.valid || tick_taken) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = pending_ticks.pop_front();
          tick_ch.sample_valid  <= w.sample_valid;
          tick_ch.humidity      <= w.humidity;
          tick_ch.motion_seen   <= w.motion_seen;
          tick_ch.clock_valid   <= w.clock_valid;
          tick_ch.minute_of_day <= w.minute_of_day;
          tick_ch.switch_flip   <= w.switch_flip;
          tick_ch.valid         <= 1'b1;
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
      tick_taken = 1'b0;
    end
  end

  always @(posedge clk) begin
    efrc_pkg::tick_t   t;
    efrc_pkg::result_t want;
    efrc_pkg::result_t got;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      if (!rst && tick_ch.valid && tick_ch.ready) begin
        t.sample_valid  = tick_ch.sample_valid;
        t.humidity      = tick_ch.humidity;
        t.motion_seen   = tick_ch.motion_seen;
        t.clock_valid   = tick_ch.clock_valid;
        t.minute_of_day = tick_ch.minute_of_day;
        t.switch_flip   = tick_ch.switch_flip;
        predict_fan_tick(t, want);
        expected_outputs.push_back(want);
        tick_taken = 1'b1;
      end
      if (!rst && result_ch.valid && result_ch.ready) begin
        got.relay_drive = result_ch.relay_drive;
        got.humid_flag  = result_ch.humid_flag;
        got.run_left    = result_ch.run_left;
        got.lock_left   = result_ch.lock_left;
        if (expected_outputs.size() == 0) begin
          report_mismatch("unexpected word, run_left", 0, 32'(got.run_left));
        end else begin
          want = expected_outputs.pop_front();
          if (got.relay_drive !== want.relay_drive) begin
            report_mismatch("relay_drive", 32'(want.relay_drive), 32'(got.relay_drive));
          end
          if (got.humid_flag !== want.humid_flag) begin
            report_mismatch("humid_flag", 32'(want.humid_flag), 32'(got.humid_flag));
          end
          if (got.run_left !== want.run_left) begin
            report_mismatch("run_left", 32'(want.run_left), 32'(got.run_left));
          end
          if (got.lock_left !== want.lock_left) begin
            report_mismatch("lock_left", 32'(want.lock_left), 32'(got.lock_left));
          end
        end
      end
    end
  end

  initial begin
    efrc_pkg::cfg_t c;
    rst                   = 1'b1;
    cfg_write             = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    tick_ch.valid         = 1'b0;
    tick_ch.sample_valid  = 1'b0;
    tick_ch.humidity      = '0;
    tick_ch.motion_seen   = 1'b0;
    tick_ch.clock_valid   = 1'b0;
    tick_ch.minute_of_day = '0;
    tick_ch.switch_flip   = 1'b0;
    result_ch.ready       = 1'b0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    mismatch_count        = 0;
    cycle_count           = 0;
    tick_taken            = 1'b0;

    fan_cfg.humid_on_level      = efrc_pkg::HUMID_ON_RESET;
    fan_cfg.humid_off_level     = efrc_pkg::HUMID_OFF_RESET;
    fan_cfg.presence_run_ticks  = efrc_pkg::PRESENCE_RESET;
    fan_cfg.humid_run_ticks     = efrc_pkg::HUMID_RUN_RESET;
    fan_cfg.humid_min_ticks     = efrc_pkg::HUMID_MIN_RESET;
    fan_cfg.lockout_ticks       = efrc_pkg::LOCKOUT_RESET;
    fan_cfg.ignore_start_minute = efrc_pkg::IGNORE_START_RESET;
    fan_cfg.ignore_end_minute   = efrc_pkg::IGNORE_END_RESET;
    run_cnt     = '0;
    lock_cnt    = efrc_pkg::RESET_LOCK_TICKS;
    humid_hi    = 1'b0;
    motion_pend = 1'b0;
    fan_running = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default settings: hysteresis edges, out-of-range values, pending motion,
    // the wrapping ignore window and the switch in both directions.
    pending_ticks.push_back(make_tick(1, 1000, 0, 0, 0, 0));
    pending_ticks.push_back(make_tick(1, 0, 0, 0, 0, 0));
    pending_ticks.push_back(make_tick(1, 1023, 0, 0, 0, 0));
    pending_ticks.push_back(make_tick(1, 550, 0, 0, 0, 0));
    pending_ticks.push_back(make_tick(1, 600, 0, 0, 0, 0));
    pending_ticks.push_back(make_tick(1, 575, 1, 0, 2047, 0));
    pending_ticks.push_back(make_tick(0, 0, 0, 1, 700, 0));
    pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, 1));
    pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, 1));
    pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, 1));
    pending_ticks.push_back(make_tick(0, 0, 1, 1, 1320, 0));
    pending_ticks.push_back(make_tick(0, 0, 1, 1, 359, 0));
    pending_ticks.push_back(make_tick(0, 0, 1, 1, 0, 0));
    pending_ticks.push_back(make_tick(0, 0, 1, 1, 2047, 0));
    pending_ticks.push_back(make_tick(0, 0, 1, 1, 360, 0));
    pending_ticks.push_back(make_tick(1, 1023, 1, 1, 2047, 1));
    pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, 0));
    wait_for_drain();

    // Crossed levels, a window with equal bounds, and the short lockout
    // that follows a run which expires on its own.
    c = fan_cfg;
    c.humid_on_level      = HUM_BITS'(500);
    c.humid_off_level     = HUM_BITS'(700);
    c.presence_run_ticks  = CNT_BITS'(3);
    c.ignore_start_minute = MIN_BITS'(100);
    c.ignore_end_minute   = MIN_BITS'(100);
    apply_settings(c);
    pending_ticks.push_back(make_tick(1, 600, 0, 0, 0, 0));
    pending_ticks.push_back(make_tick(1, 500, 1, 1, 100, 0));
    pending_ticks.push_back(make_tick(0, 0, 1, 1, 50, 0));
    pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, 1));
    pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, 0));
    wait_for_drain();

    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        2:       apply_settings(random_settings(1));
        5:       apply_settings(random_settings(2));
        8, 10:   apply_settings(random_settings(3));
        default: apply_settings(random_settings(0));
      endcase
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 78;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 78;
        end
        default: begin
          send_idle_pct  = 7;
          recv_stall_pct = 7;
        end
      endcase
      for (int unsigned i = 0; i < RANDOM_TICKS / PHASES; i++) begin
        pending_ticks.push_back(random_tick());
      end
      wait_for_drain();
    end

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/efrc_pkg.sv
rtl/efrc_if.sv
rtl/efrc_step.sv
rtl/exhaust_fan_relay_controller_top.sv
rtl/efrc_checker.sv
sim/tb_exhaust_fan_relay_controller_top.sv
